@@ sv/hdia_pkg.sv @@
// hdia_pkg: shared types and constants of the hash dedup id assigner
// used by hdia_cell, hdia_ctl and hash_dedup_id_assigner_core; no dependencies

package hdia_pkg;

  // fixed field widths of the stream payloads
  localparam int unsigned KeyFieldW = 64;
  localparam int unsigned IdW       = 8;
  localparam int unsigned OutDataW  = 16;

  // control sequencer states
  typedef enum logic [0:0] {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } hdia_state_t;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic cmp_en;   // latch compare flags against the incoming key
    logic ins_en;   // shift up and insert the held key
  } cell_cmd_t;

endpackage

@@ sv/hdia_cell.sv @@
// hdia_cell: one table cell holding a key, its id and a valid bit
// depends on hdia_pkg; chained by hash_dedup_id_assigner_core

module hdia_cell #(
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  hdia_pkg::cell_cmd_t          cmd,
  input  logic [KEY_BITS-1:0]          cmp_key,
  input  logic [KEY_BITS-1:0]          new_key,
  input  logic [hdia_pkg::IdW-1:0]     new_id,
  input  logic [KEY_BITS-1:0]          prev_key,
  input  logic [hdia_pkg::IdW-1:0]     prev_id,
  input  logic                         prev_valid,
  input  logic                         prev_ins,
  output logic [KEY_BITS-1:0]          key,
  output logic [hdia_pkg::IdW-1:0]     id,
  output logic                         valid,
  output logic                         ins_flag,
  output logic                         eq_flag,
  output logic [hdia_pkg::IdW-1:0]     match_id
);

  logic [KEY_BITS-1:0]      key_r;
  logic [hdia_pkg::IdW-1:0] id_r;
  logic                     valid_r;
  logic                     eq_r;
  logic                     ins_r;

  // compare flags, taken in the accept cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eq_r  <= 1'b0;
      ins_r <= 1'b0;
    end else if (cmd.cmp_en) begin
      eq_r  <= valid_r && (key_r == cmp_key);
      ins_r <= !valid_r || (key_r > cmp_key);
    end
  end

  // valid bit: an empty cell fills when the left neighbor is valid or it is the insert spot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (cmd.ins_en && ins_r) begin
      valid_r <= prev_ins ? prev_valid : 1'b1;
    end
  end

  // payload: take the neighbor's entry or the new key at the insert spot
  always_ff @(posedge clk) begin
    if (cmd.ins_en && ins_r) begin
      if (prev_ins) begin
        key_r <= prev_key;
        id_r  <= prev_id;
      end else begin
        key_r <= new_key;
        id_r  <= new_id;
      end
    end
  end

  assign key      = key_r;
  assign id       = id_r;
  assign valid    = valid_r;
  assign ins_flag = ins_r;
  assign eq_flag  = eq_r;
  assign match_id = eq_r ? id_r : '0;

endmodule

@@ sv/hdia_ctl.sv @@
// hdia_ctl: sequencer, entry count and result register
// depends on hdia_pkg; instantiated by hash_dedup_id_assigner_core

module hdia_ctl #(
  parameter int unsigned TABLE_DEPTH = 256,
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic                      any_eq,
  input  logic [hdia_pkg::IdW-1:0]  hit_id,
  output hdia_pkg::cell_cmd_t       cmd,
  output logic [hdia_pkg::IdW-1:0]  new_id,
  output logic [CntW-1:0]           count,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [hdia_pkg::IdW-1:0]  res_id,
  output logic                      res_new,
  output logic                      res_full
);

  localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);

  hdia_pkg::hdia_state_t    state_r, state_nxt;
  logic [CntW-1:0]          count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [hdia_pkg::IdW-1:0] id_r, id_nxt;
  logic                     new_r, new_nxt;
  logic                     full_r, full_nxt;
  logic                     commit;
  logic                     tbl_full;

  assign tbl_full = (count_r == DepthC);
  assign new_id   = hdia_pkg::IdW'(count_r);

  // next state, cell commands and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    id_nxt        = id_r;
    new_nxt       = new_r;
    full_nxt      = full_r;
    commit        = 1'b0;
    in_tready     = 1'b0;
    cmd           = '0;
    unique case (state_r)
      hdia_pkg::ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.cmp_en = in_tvalid;
        if (in_tvalid) begin
          state_nxt = hdia_pkg::ST_UPDATE;
        end
      end
      hdia_pkg::ST_UPDATE: begin
        commit = !out_valid_r || out_tready;
        if (commit) begin
          state_nxt     = hdia_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
          priority if (any_eq) begin
            id_nxt   = hit_id;
            new_nxt  = 1'b0;
            full_nxt = 1'b0;
          end else if (tbl_full) begin
            id_nxt   = '0;
            new_nxt  = 1'b0;
            full_nxt = 1'b1;
          end else begin
            cmd.ins_en = 1'b1;
            id_nxt     = new_id;
            new_nxt    = 1'b1;
            full_nxt   = 1'b0;
            count_nxt  = count_r + CntW'(1);
          end
        end
      end
      default: begin
        state_nxt = hdia_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hdia_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    new_r  <= new_nxt;
    full_r <= full_nxt;
  end

  assign count      = count_r;
  assign out_tvalid = out_valid_r;
  assign res_id     = id_r;
  assign res_new    = new_r;
  assign res_full   = full_r;

endmodule

@@ sv/hash_dedup_id_assigner_core.sv @@
// hash_dedup_id_assigner_core: sorted cell-chain key table assigning dense ids
// depends on hdia_pkg, hdia_cell and hdia_ctl
//
// channel | dir | ports                      | payload
// in_     | in  | tvalid tready tdata[63:0]  | key
// out_    | out | tvalid tready tdata[15:0]  | assigned_id, was_new, table_full
//
// per item, the accept state compares the key against every cell in parallel
// into per-cell flags, then the update state shifts the chain up by one from
// the insert spot and loads the result register
// a waiting result does not block acceptance; the update cycle holds while the
// result register is still occupied and not taken
// reset clears the sequencer, the entry count and the cell valid bits

module hash_dedup_id_assigner_core #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_BITS    = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hdia_pkg::KeyFieldW-1:0]  in_tdata,   // [63:0] key
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hdia_pkg::OutDataW-1:0]   out_tdata   // [7:0] assigned_id, [8] was_new,
                                                      // [9] table_full, [15:10] zero
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  hdia_pkg::cell_cmd_t      cmd;
  logic [KEY_BITS-1:0]      in_key;
  logic [KEY_BITS-1:0]      key_r;
  logic [hdia_pkg::IdW-1:0] new_id;
  logic [hdia_pkg::IdW-1:0] hit_id;
  logic                     any_eq;
  logic [CntW-1:0]          count;
  logic [hdia_pkg::IdW-1:0] res_id;
  logic                     res_new;
  logic                     res_full;

  logic [KEY_BITS-1:0]      cell_key [TABLE_DEPTH];
  logic [hdia_pkg::IdW-1:0] cell_id  [TABLE_DEPTH];
  logic [hdia_pkg::IdW-1:0] cell_mid [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   cell_valid;
  logic [TABLE_DEPTH-1:0]   ins_vec;
  logic [TABLE_DEPTH-1:0]   eq_vec;

  assign in_key = in_tdata[KEY_BITS-1:0];

  // hold the accepted key for the insert cycle
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r <= in_key;
    end
  end

  // cell chain; cell 0 has no left neighbor
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    logic [KEY_BITS-1:0]      p_key;
    logic [hdia_pkg::IdW-1:0] p_id;
    logic                     p_valid;
    logic                     p_ins;
    if (g == 0) begin : g_head
      assign p_key   = '0;
      assign p_id    = '0;
      assign p_valid = 1'b0;
      assign p_ins   = 1'b0;
    end else begin : g_link
      assign p_key   = cell_key[g-1];
      assign p_id    = cell_id[g-1];
      assign p_valid = cell_valid[g-1];
      assign p_ins   = ins_vec[g-1];
    end
    hdia_cell #(
      .KEY_BITS(KEY_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .cmp_key    (in_key),
      .new_key    (key_r),
      .new_id     (new_id),
      .prev_key   (p_key),
      .prev_id    (p_id),
      .prev_valid (p_valid),
      .prev_ins   (p_ins),
      .key        (cell_key[g]),
      .id         (cell_id[g]),
      .valid      (cell_valid[g]),
      .ins_flag   (ins_vec[g]),
      .eq_flag    (eq_vec[g]),
      .match_id   (cell_mid[g])
    );
  end

  // at most one cell matches, so an or over the masked ids picks its id
  always_comb begin
    hit_id = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      hit_id = hit_id | cell_mid[i];
    end
  end

  assign any_eq = |eq_vec;

  hdia_ctl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .any_eq     (any_eq),
    .hit_id     (hit_id),
    .cmd        (cmd),
    .new_id     (new_id),
    .count      (count),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .res_id     (res_id),
    .res_new    (res_new),
    .res_full   (res_full)
  );

  assign out_tdata = {6'b0, res_full, res_new, res_id};

  // stored keys are distinct, so at most one cell flags a match
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(eq_vec))
    else $error("more than one cell matched the key");

  // insert flags form one rising edge along the sorted chain
  a_ins_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ins_vec ^ {ins_vec[TABLE_DEPTH-2:0], 1'b0}))
    else $error("insert flags are not monotone along the chain");

  // the number of valid cells tracks the entry count
  a_count_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(count))
    else $error("valid cells disagree with the entry count");

  // a result never says both inserted and refused
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(res_new && res_full))
    else $error("result marked both new and full");

endmodule
